// ----- hdl/mibc_pkg.sv -----
// ----------------------------------------------------------------------------
// mibc_pkg: shared types and constants of the bead centroid unit
// Register indexes, internal datapath widths, controller-to-datapath command
// and status structs, and the saturation helper used by the datapath.
// ----------------------------------------------------------------------------
package mibc_pkg;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int NUM_REGS   = 6;

	localparam logic [CFG_ADDR_W-1:0] REG_BOX_LX_LY = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BOX_LZ_XY = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BOX_XZ_YZ = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_00_11 = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_22_01 = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_02_12 = 3'd5;

	typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] cfg_regs_t;

	// Fixed field widths
	localparam int WEIGHT_W = 17;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

	// Datapath widths
	localparam int MAT_W       = 32;  // box and inverse entries
	localparam int OPB_W       = 26;  // second multiplier operand
	localparam int PROD_W      = MAT_W + OPB_W;
	localparam int ACC_W       = 60;  // per-half accumulators
	localparam int COMB_W      = 84;  // recombined halves
	localparam int HALF_SHIFT  = 24;  // split point of wide operands
	localparam int DISP_W      = 47;  // saturated displacement
	localparam int DS_W        = 26;  // image offset, [-2^24, 2^24]
	localparam int DN_W        = 60;  // wrapped displacement
	localparam int SUM_W       = 56;  // weighted sum, Q24.32
	localparam int P_W         = 48;  // position, widest coordinate
	localparam int ROUND_SHIFT = 46;  // Q2.30 times Q16.16 down to integer
	localparam int Q_W         = COMB_W - ROUND_SHIFT;

	localparam logic [COMB_W-1:0] RND_BIAS = COMB_W'(1) << (ROUND_SHIFT - 1);
	localparam logic [Q_W-1:0]    DS_LIM   = Q_W'(1) << 24;

	localparam logic signed [63:0] SUM_MAX64  = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
	localparam logic signed [63:0] SUM_MIN64  = -(64'sd1 <<< (SUM_W - 1));
	localparam logic signed [63:0] DISP_MAX64 = (64'sd1 <<< (DISP_W - 1)) - 64'sd1;
	localparam logic signed [63:0] DISP_MIN64 = -(64'sd1 <<< (DISP_W - 1));
	localparam logic signed [63:0] EMIT_BIAS  = 64'sd32768;

	// Accumulator operation of a lane
	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_op_t;

	// Operand set fed to the multipliers
	typedef enum logic [1:0] {
		OPS_INV  = 2'd0,  // inverse box times displacement halves
		OPS_BOX  = 2'd1,  // box times image offset
		OPS_WGT  = 2'd2   // position halves times weight
	} op_sel_t;

	typedef struct packed {
		acc_op_t acc_op;
		logic    comb_en;
	} lane_cmd_t;

	typedef struct packed {
		logic      load_in;
		logic      disp;
		op_sel_t   op_sel;
		logic [1:0] col;
		lane_cmd_t lane;
		logic      rnd;
		logic      sub;
		logic      pos;
		logic      pcl;
		logic      accum;
		logic      emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_sts_t;

	function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
		input logic signed [63:0] lo, input logic signed [63:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

endpackage

// ----- hdl/min_image_weighted_bead_centroid_unit.sv -----
// ----------------------------------------------------------------------------
// min_image_weighted_bead_centroid_unit: weighted bead centroid, triclinic box
// Accumulates minimum-image wrapped, weighted atom positions of a bead.
// ----------------------------------------------------------------------------
// Usage:
//  Atoms enter on the s_ group: tuser marks the reference atom that starts a
//  bead, tlast marks the final atom. On the final atom one item leaves on the
//  m_ group with the bead position and the bead id of that atom.
//  The box and its inverse are set through cfg_we / cfg_addr / cfg_wdata
//  while no atom is in flight; indexes beyond the register list are ignored.
//  Each atom is worked through before the next one can be taken. An atom
//  goes in turn through three passes of the per-row multiplier lanes
//  (inverse matrix, box matrix, weight), each followed by a recombine step;
//  the inverse pass is also followed by a round step.
//  The result is registered after the final atom, once the output is free.
//  The output register holds a result while the receiver stalls; the unit
//  keeps taking atoms and only waits when a second result is ready.
//  Reset clears the box registers, the reference and the sums to zero.
// ----------------------------------------------------------------------------
module min_image_weighted_bead_centroid_unit #(
	parameter int COORD_WIDTH   = 32,
	parameter int BEAD_ID_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	// atom_x, atom_y, atom_z, weight, bead_id, zero padding
	input  logic [((3*COORD_WIDTH+mibc_pkg::WEIGHT_W+BEAD_ID_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic s_tlast,   // last_of_bead
	input  logic s_tuser,   // first_of_bead
	// bead_x, bead_y, bead_z, bead_out_id, zero padding
	output logic [((3*COORD_WIDTH+BEAD_ID_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic cfg_we,
	input  logic [mibc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [mibc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mibc_pkg::*;

	localparam int W_LO  = 3 * COORD_WIDTH;
	localparam int ID_LO = W_LO + WEIGHT_W;

	cfg_regs_t cfg_q;
	dp_cmd_t   cmd;
	dp_sts_t   sts;

	logic signed [COORD_WIDTH-1:0] bead_x, bead_y, bead_z;
	logic [BEAD_ID_WIDTH-1:0]      bead_out_id;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we && (cfg_addr < CFG_ADDR_W'(NUM_REGS))) begin
			cfg_q[cfg_addr] <= cfg_wdata;
		end
	end

	mibc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mibc_dpath #(
		.COORD_WIDTH   (COORD_WIDTH),
		.BEAD_ID_WIDTH (BEAD_ID_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.atom_x        ($signed(s_tdata[COORD_WIDTH-1:0])),
		.atom_y        ($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
		.atom_z        ($signed(s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
		.weight        (s_tdata[ID_LO-1:W_LO]),
		.first_of_bead (s_tuser),
		.last_of_bead  (s_tlast),
		.bead_id       (s_tdata[ID_LO+BEAD_ID_WIDTH-1:ID_LO]),
		.bead_x        (bead_x),
		.bead_y        (bead_y),
		.bead_z        (bead_z),
		.bead_out_id   (bead_out_id)
	);

	// Pack the result item
	always_comb begin
		m_tdata = '0;
		m_tdata[COORD_WIDTH-1:0]               = bead_x;
		m_tdata[2*COORD_WIDTH-1:COORD_WIDTH]   = bead_y;
		m_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH] = bead_z;
		m_tdata[W_LO+BEAD_ID_WIDTH-1:W_LO]     = bead_out_id;
	end

endmodule

// ----- hdl/mibc_lane.sv -----
// ----------------------------------------------------------------------------
// mibc_lane: multiply-accumulate lane for one row of the box matrices
// Two signed multipliers with registered products, two accumulators for the
// low and high operand halves, and a register that recombines the halves.
// ----------------------------------------------------------------------------
module mibc_lane (
	input  logic                                  clk,
	input  logic signed [mibc_pkg::MAT_W-1:0]     a0,
	input  logic signed [mibc_pkg::MAT_W-1:0]     a1,
	input  logic signed [mibc_pkg::OPB_W-1:0]     b0,
	input  logic signed [mibc_pkg::OPB_W-1:0]     b1,
	input  mibc_pkg::lane_cmd_t                   cmd,
	output logic signed [mibc_pkg::COMB_W-1:0]    comb
);
	import mibc_pkg::*;

	logic signed [PROD_W-1:0] prod0_s1, prod1_s1;
	logic signed [ACC_W-1:0]  acc0_q, acc1_q;
	logic signed [COMB_W-1:0] comb_q;

	// Register the products every cycle
	always_ff @(posedge clk) begin
		prod0_s1 <= PROD_W'(a0) * PROD_W'(b0);
		prod1_s1 <= PROD_W'(a1) * PROD_W'(b1);
	end

	// Load or add the products into the half accumulators
	always_ff @(posedge clk) begin
		case (cmd.acc_op)
			ACC_LOAD: begin
				acc0_q <= ACC_W'(prod0_s1);
				acc1_q <= ACC_W'(prod1_s1);
			end
			ACC_ADD: begin
				acc0_q <= acc0_q + ACC_W'(prod0_s1);
				acc1_q <= acc1_q + ACC_W'(prod1_s1);
			end
			default: begin
				acc0_q <= acc0_q;
				acc1_q <= acc1_q;
			end
		endcase
	end

	// Recombine low and shifted high half
	always_ff @(posedge clk) begin
		if (cmd.comb_en) begin
			comb_q <= COMB_W'(acc0_q) + (COMB_W'(acc1_q) <<< HALF_SHIFT);
		end
	end

	assign comb = comb_q;

endmodule

// ----- hdl/mibc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mibc_ctrl: sequencer of the bead centroid unit
// Steps each atom through displacement, image offset, wrap, weighting and
// accumulation, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module mibc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output mibc_pkg::dp_cmd_t  cmd,
	input  mibc_pkg::dp_sts_t  sts
);
	import mibc_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_DISP = 14'b00000000000010,
		ST_TMUL = 14'b00000000000100,
		ST_TCMB = 14'b00000000001000,
		ST_RND  = 14'b00000000010000,
		ST_CMUL = 14'b00000000100000,
		ST_CCMB = 14'b00000001000000,
		ST_SUB  = 14'b00000010000000,
		ST_POS  = 14'b00000100000000,
		ST_WMUL = 14'b00001000000000,
		ST_WCMB = 14'b00010000000000,
		ST_PCL  = 14'b00100000000000,
		ST_ACC  = 14'b01000000000000,
		ST_EMIT = 14'b10000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] step_q, step_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	// Accumulator op of a three-column pass: issue, load, add, add
	function automatic acc_op_t pass_op(input logic [1:0] step);
		case (step)
			2'd0:    return ACC_HOLD;
			2'd1:    return ACC_LOAD;
			default: return ACC_ADD;
		endcase
	endfunction

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		cmd         = '0;
		cmd.op_sel  = OPS_INV;
		cmd.col     = step_q;
		cmd.lane.acc_op = ACC_HOLD;
		s_tready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DISP;
				end
			end
			ST_DISP: begin
				cmd.disp = 1'b1;
				step_d   = 2'd0;
				state_d  = ST_TMUL;
			end
			ST_TMUL: begin
				cmd.op_sel      = OPS_INV;
				cmd.lane.acc_op = pass_op(step_q);
				step_d          = step_q + 2'd1;
				if (step_q == 2'd3) begin
					state_d = ST_TCMB;
				end
			end
			ST_TCMB: begin
				cmd.lane.comb_en = 1'b1;
				state_d          = ST_RND;
			end
			ST_RND: begin
				cmd.rnd = 1'b1;
				step_d  = 2'd0;
				state_d = ST_CMUL;
			end
			ST_CMUL: begin
				cmd.op_sel      = OPS_BOX;
				cmd.lane.acc_op = pass_op(step_q);
				step_d          = step_q + 2'd1;
				if (step_q == 2'd3) begin
					state_d = ST_CCMB;
				end
			end
			ST_CCMB: begin
				cmd.lane.comb_en = 1'b1;
				state_d          = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = ST_POS;
			end
			ST_POS: begin
				cmd.pos = 1'b1;
				step_d  = 2'd0;
				state_d = ST_WMUL;
			end
			ST_WMUL: begin
				cmd.op_sel      = OPS_WGT;
				cmd.lane.acc_op = (step_q == 2'd0) ? ACC_HOLD : ACC_LOAD;
				step_d          = step_q + 2'd1;
				if (step_q == 2'd1) begin
					state_d = ST_WCMB;
				end
			end
			ST_WCMB: begin
				cmd.lane.comb_en = 1'b1;
				state_d          = ST_PCL;
			end
			ST_PCL: begin
				cmd.pcl = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_d   = sts.last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/mibc_dpath.sv -----
// ----------------------------------------------------------------------------
// mibc_dpath: datapath of the bead centroid unit
// Holds the atom, the reference and the sums, selects multiplier operands
// for three row lanes, and does the rounding, wrapping and saturation steps.
// ----------------------------------------------------------------------------
module mibc_dpath #(
	parameter int COORD_WIDTH   = 32,
	parameter int BEAD_ID_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mibc_pkg::cfg_regs_t                  cfg,
	input  mibc_pkg::dp_cmd_t                    cmd,
	output mibc_pkg::dp_sts_t                    sts,
	input  logic signed [COORD_WIDTH-1:0]        atom_x,
	input  logic signed [COORD_WIDTH-1:0]        atom_y,
	input  logic signed [COORD_WIDTH-1:0]        atom_z,
	input  logic [mibc_pkg::WEIGHT_W-1:0]        weight,
	input  logic                                 first_of_bead,
	input  logic                                 last_of_bead,
	input  logic [BEAD_ID_WIDTH-1:0]             bead_id,
	output logic signed [COORD_WIDTH-1:0]        bead_x,
	output logic signed [COORD_WIDTH-1:0]        bead_y,
	output logic signed [COORD_WIDTH-1:0]        bead_z,
	output logic [BEAD_ID_WIDTH-1:0]             bead_out_id
);
	import mibc_pkg::*;

	localparam logic signed [63:0] CMAX64 = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] CMIN64 = -(64'sd1 <<< (COORD_WIDTH - 1));

	logic signed [COORD_WIDTH-1:0] atom [3];
	logic signed [COORD_WIDTH-1:0] pos_q [3];
	logic signed [COORD_WIDTH-1:0] ref_q [3];
	logic signed [COORD_WIDTH-1:0] p_q [3];
	logic signed [COORD_WIDTH-1:0] out_q [3];
	logic [WEIGHT_W-1:0]           w_q;
	logic                          last_q;
	logic [BEAD_ID_WIDTH-1:0]      id_q, id_out_q;
	logic signed [DISP_W-1:0]      d_q [3];
	logic signed [DS_W-1:0]        s_q [3];
	logic signed [DN_W-1:0]        dn_q [3];
	logic signed [SUM_W-1:0]       prodc_q [3];
	logic signed [SUM_W-1:0]       sum_q [3];

	logic signed [MAT_W-1:0]  hm [3][4];
	logic signed [MAT_W-1:0]  im [3][4];
	logic signed [DISP_W-1:0] dcol [4];
	logic signed [DS_W-1:0]   scol [4];
	logic signed [MAT_W-1:0]  a0 [3], a1 [3];
	logic signed [OPB_W-1:0]  b0 [3], b1 [3];
	logic signed [COMB_W-1:0] comb [3];
	logic signed [DS_W-1:0]   s_nx [3];
	logic [WEIGHT_W-1:0]      w_sat;

	assign atom[0] = atom_x;
	assign atom[1] = atom_y;
	assign atom[2] = atom_z;
	assign w_sat   = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
	assign sts.last = last_q;

	// Box rows and inverse rows, upper triangular, padded with a zero column
	always_comb begin
		hm[0][0] = cfg[REG_BOX_LX_LY][31:0];
		hm[0][1] = cfg[REG_BOX_LZ_XY][63:32];
		hm[0][2] = cfg[REG_BOX_XZ_YZ][31:0];
		hm[1][0] = '0;
		hm[1][1] = cfg[REG_BOX_LX_LY][63:32];
		hm[1][2] = cfg[REG_BOX_XZ_YZ][63:32];
		hm[2][0] = '0;
		hm[2][1] = '0;
		hm[2][2] = cfg[REG_BOX_LZ_XY][31:0];
		im[0][0] = cfg[REG_INV_00_11][31:0];
		im[0][1] = cfg[REG_INV_22_01][63:32];
		im[0][2] = cfg[REG_INV_02_12][31:0];
		im[1][0] = '0;
		im[1][1] = cfg[REG_INV_00_11][63:32];
		im[1][2] = cfg[REG_INV_02_12][63:32];
		im[2][0] = '0;
		im[2][1] = '0;
		im[2][2] = cfg[REG_INV_22_01][31:0];
		for (int k = 0; k < 3; k++) begin
			hm[k][3] = '0;
			im[k][3] = '0;
			dcol[k]  = d_q[k];
			scol[k]  = s_q[k];
		end
		dcol[3] = '0;
		scol[3] = '0;
	end

	// Select multiplier operands for each lane
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [P_W-1:0] p48;
			p48   = P_W'(p_q[k]);
			a0[k] = '0;
			a1[k] = '0;
			b0[k] = '0;
			b1[k] = '0;
			case (cmd.op_sel)
				OPS_INV: begin
					a0[k] = im[k][cmd.col];
					a1[k] = im[k][cmd.col];
					b0[k] = $signed({{(OPB_W-HALF_SHIFT){1'b0}},
						dcol[cmd.col][HALF_SHIFT-1:0]});
					b1[k] = OPB_W'(dcol[cmd.col] >>> HALF_SHIFT);
				end
				OPS_BOX: begin
					a0[k] = hm[k][cmd.col];
					b0[k] = scol[cmd.col];
				end
				OPS_WGT: begin
					a0[k] = $signed({{(MAT_W-HALF_SHIFT){1'b0}}, p48[HALF_SHIFT-1:0]});
					a1[k] = MAT_W'(p48 >>> HALF_SHIFT);
					b0[k] = $signed({{(OPB_W-WEIGHT_W){1'b0}}, w_q});
					b1[k] = $signed({{(OPB_W-WEIGHT_W){1'b0}}, w_q});
				end
				default: begin
					a0[k] = '0;
				end
			endcase
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		mibc_lane u_lane (
			.clk  (clk),
			.a0   (a0[k]),
			.a1   (a1[k]),
			.b0   (b0[k]),
			.b1   (b1[k]),
			.cmd  (cmd.lane),
			.comb (comb[k])
		);
	end

	// Round the scaled offset half away from zero and clamp it
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic              neg;
			logic [COMB_W-1:0] mag;
			logic [Q_W-1:0]    q;
			logic [DS_W-1:0]   qc;
			neg = comb[k][COMB_W-1];
			mag = (neg ? ~$unsigned(comb[k]) : $unsigned(comb[k]))
				+ (neg ? RND_BIAS + COMB_W'(1) : RND_BIAS);
			q   = mag[COMB_W-1:ROUND_SHIFT];
			qc  = (q > DS_LIM) ? DS_W'(DS_LIM) : q[DS_W-1:0];
			s_nx[k] = neg ? -$signed(qc) : $signed(qc);
		end
	end

	// Capture the atom
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= atom[k];
			end
			w_q    <= w_sat;
			last_q <= last_of_bead;
			id_q   <= bead_id;
		end
	end

	// Reference and weighted sums: restart on a first atom, advance per atom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				ref_q[k] <= '0;
				sum_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (cmd.load_in && first_of_bead) begin
					ref_q[k] <= atom[k];
					sum_q[k] <= '0;
				end else if (cmd.accum) begin
					sum_q[k] <= SUM_W'(sat64(64'(sum_q[k]) + 64'(prodc_q[k]),
						SUM_MIN64, SUM_MAX64));
				end
			end
		end
	end

	// Displacement, offset, wrap and weighted product steps
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.disp) begin
				d_q[k] <= DISP_W'(sat64(64'(pos_q[k]) - 64'(ref_q[k]),
					DISP_MIN64, DISP_MAX64));
			end
			if (cmd.rnd) begin
				s_q[k] <= s_nx[k];
			end
			if (cmd.sub) begin
				dn_q[k] <= DN_W'(d_q[k]) - DN_W'(comb[k]);
			end
			if (cmd.pos) begin
				p_q[k] <= COORD_WIDTH'(sat64(64'(ref_q[k]) + 64'(dn_q[k]), CMIN64, CMAX64));
			end
			if (cmd.pcl) begin
				prodc_q[k] <= SUM_W'(sat64($signed(comb[k][63:0]), SUM_MIN64, SUM_MAX64));
			end
		end
	end

	// Round the sums to Q16.16 into the output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int k = 0; k < 3; k++) begin
				out_q[k] <= COORD_WIDTH'(sat64((64'(sum_q[k]) + EMIT_BIAS) >>> 16,
					CMIN64, CMAX64));
			end
			id_out_q <= id_q;
		end
	end

	assign bead_x      = out_q[0];
	assign bead_y      = out_q[1];
	assign bead_z      = out_q[2];
	assign bead_out_id = id_out_q;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the weighted bead centroid unit
// Streams beads of atoms through the unit under several box settings, from
// all-zero and hand-picked extremes to random triclinic boxes with matching
// inverses. A scoreboard predicts every bead position from the accepted atoms
// and compares each field of every result item in order.
// ----------------------------------------------------------------------------
module tb_top;
	import mibc_pkg::*;

	localparam int COORD_W  = 32;
	localparam int ID_W     = 16;
	localparam int S_DATA_W = ((3*COORD_W + WEIGHT_W + ID_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((3*COORD_W + ID_W + 7) / 8) * 8;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;

	// Index past the register list; writes to it must change nothing
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

	localparam longint C_HI    = 64'sd2147483647;
	localparam longint C_LO    = -64'sd2147483648;
	localparam longint SUM_HI  = (64'sd1 <<< 55) - 64'sd1;
	localparam longint SUM_LO  = -(64'sd1 <<< 55);
	localparam longint DISP_HI = (64'sd1 <<< 46) - 64'sd1;
	localparam longint DISP_LO = -(64'sd1 <<< 46);
	localparam longint SHIFT_LIM = 64'sd1 <<< 24;
	localparam longint W_ONE   = 64'sd65536;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [WEIGHT_W-1:0]       weight;
		logic                      first;
		logic                      last;
		logic [ID_W-1:0]           id;
	} atom_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [ID_W-1:0]    id;
	} bead_t;

	typedef enum {
		BEAD_CLEAN,
		BEAD_NO_FIRST,
		BEAD_NO_LAST,
		BEAD_MIXED_ID,
		BEAD_EDGE
	} bead_kind_t;

	// ------------------------------------------------------------------
	// Scoreboard: own copy of box, reference and sums; due bead positions
	// ------------------------------------------------------------------
	class centroid_board;
		logic [CFG_DATA_W-1:0] regs [NUM_REGS];
		longint ref_x, ref_y, ref_z;
		longint sum_x, sum_y, sum_z;
		bead_t  beads_due [$];
		int     errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			ref_x = 0;
			ref_y = 0;
			ref_z = 0;
			sum_x = 0;
			sum_y = 0;
			sum_z = 0;
			errors = 0;
		endfunction

		static function longint sat(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx < NUM_REGS)
				regs[idx] = val;
		endfunction

		function longint reg_half(logic [CFG_ADDR_W-1:0] idx, bit upper);
			logic [CFG_DATA_W-1:0] r;
			r = regs[idx];
			return upper ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
		endfunction

		// Nearest image count along one row: round half away from zero of
		// the exact dot product scaled down by 2^46, then limit it
		function longint image_shift(longint a0, longint a1, longint a2,
			longint d0, longint d1, longint d2);
			logic signed [127:0] e0, e1, e2, f0, f1, f2, t, mag;
			longint q;
			e0 = a0;
			e1 = a1;
			e2 = a2;
			f0 = d0;
			f1 = d1;
			f2 = d2;
			t = e0 * f0 + e1 * f1 + e2 * f2;
			mag = (t < 0) ? -t : t;
			mag = (mag + (128'sd1 <<< 45)) >>> 46;
			q = longint'(mag);
			if (t < 0)
				q = -q;
			return sat(q, -SHIFT_LIM, SHIFT_LIM);
		endfunction

		function longint add_weighted(longint s, longint p, longint w);
			return sat(s + sat(p * w, SUM_LO, SUM_HI), SUM_LO, SUM_HI);
		endfunction

		function logic [COORD_W-1:0] bead_coord(longint s);
			return COORD_W'(sat((s + 64'sd32768) >>> 16, C_LO, C_HI));
		endfunction

		// Wrap one accepted atom around the reference and add it to the sums
		function void note_atom(atom_t a);
			longint ax, ay, az, w, dx, dy, dz, sx, sy, sz;
			bead_t b;
			ax = longint'($signed(a.x));
			ay = longint'($signed(a.y));
			az = longint'($signed(a.z));
			w = (longint'(a.weight) > W_ONE) ? W_ONE : longint'(a.weight);
			if (a.first) begin
				ref_x = ax;
				ref_y = ay;
				ref_z = az;
				sum_x = 0;
				sum_y = 0;
				sum_z = 0;
			end
			dx = sat(ax - ref_x, DISP_LO, DISP_HI);
			dy = sat(ay - ref_y, DISP_LO, DISP_HI);
			dz = sat(az - ref_z, DISP_LO, DISP_HI);

			sx = image_shift(reg_half(REG_INV_00_11, 0), reg_half(REG_INV_22_01, 1),
				reg_half(REG_INV_02_12, 0), dx, dy, dz);
			sy = image_shift(0, reg_half(REG_INV_00_11, 1), reg_half(REG_INV_02_12, 1),
				dx, dy, dz);
			sz = image_shift(0, 0, reg_half(REG_INV_22_01, 0), dx, dy, dz);

			dx = dx - (reg_half(REG_BOX_LX_LY, 0) * sx + reg_half(REG_BOX_LZ_XY, 1) * sy
				+ reg_half(REG_BOX_XZ_YZ, 0) * sz);
			dy = dy - (reg_half(REG_BOX_LX_LY, 1) * sy + reg_half(REG_BOX_XZ_YZ, 1) * sz);
			dz = dz - reg_half(REG_BOX_LZ_XY, 0) * sz;

			sum_x = add_weighted(sum_x, sat(ref_x + dx, C_LO, C_HI), w);
			sum_y = add_weighted(sum_y, sat(ref_y + dy, C_LO, C_HI), w);
			sum_z = add_weighted(sum_z, sat(ref_z + dz, C_LO, C_HI), w);

			if (a.last) begin
				b.x = bead_coord(sum_x);
				b.y = bead_coord(sum_y);
				b.z = bead_coord(sum_z);
				b.id = a.id;
				beads_due.insert(beads_due.size(), b);
			end
		endfunction

		function int pending();
			return beads_due.size();
		endfunction

		task report(string field, longint got, longint want);
			errors++;
			$display("%t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
		endtask

		// Compare one result item with the oldest due bead
		task check_bead(logic [M_DATA_W-1:0] d);
			bead_t want;
			if (beads_due.size() == 0) begin
				report("bead with none due", longint'(d[3*COORD_W +: ID_W]), 0);
				return;
			end
			want = beads_due.pop_front();
			if (d[0 +: COORD_W] !== want.x)
				report("bead_x", longint'(d[0 +: COORD_W]), longint'(want.x));
			if (d[COORD_W +: COORD_W] !== want.y)
				report("bead_y", longint'(d[COORD_W +: COORD_W]), longint'(want.y));
			if (d[2*COORD_W +: COORD_W] !== want.z)
				report("bead_z", longint'(d[2*COORD_W +: COORD_W]), longint'(want.z));
			if (d[3*COORD_W +: ID_W] !== want.id)
				report("bead_out_id", longint'(d[3*COORD_W +: ID_W]), longint'(want.id));
		endtask
	endclass

	// ------------------------------------------------------------------
	// Signals and block under test
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	// atom_x, atom_y, atom_z, weight, bead_id, zero padding
	logic [S_DATA_W-1:0] s_tdata;
	logic s_tvalid;
	logic s_tready;
	logic s_tlast;
	logic s_tuser;
	// bead_x, bead_y, bead_z, bead_out_id, zero padding
	logic [M_DATA_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	centroid_board board;
	int          atoms_sent = 0;
	int          hold_left = 0;
	bit          no_idle = 1'b0;
	int unsigned center_reach = 32'd1 << 20;
	int unsigned atom_reach = 32'd1 << 20;
	int          cycle_count = 0;

	min_image_weighted_bead_centroid_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Check every result item taken by the receiver
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_bead(m_tdata);
	end

	// Receiver: random stall after each item, plus a long hold when asked
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				stall_left = no_idle ? 0 : $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic atom_t mk_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [WEIGHT_W-1:0] w, bit first, bit last, logic [ID_W-1:0] id);
		atom_t a;
		a.x = x;
		a.y = y;
		a.z = z;
		a.weight = w;
		a.first = first;
		a.last = last;
		a.id = id;
		return a;
	endfunction

	function automatic logic [COORD_W-1:0] near_coord(longint c, int unsigned reach);
		longint off;
		off = longint'($urandom_range(0, 2 * reach)) - longint'(reach);
		return COORD_W'(centroid_board::sat(c + off, C_LO, C_HI));
	endfunction

	function automatic longint rim_point();
		if ($urandom_range(0, 1))
			return C_HI - longint'($urandom_range(0, 65535));
		return C_LO + longint'($urandom_range(0, 65535));
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return WEIGHT_ONE;
			1: return '0;
			2: return WEIGHT_W'($urandom);
			default: return WEIGHT_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [31:0] q16(real v);
		return 32'(longint'(v * 65536.0));
	endfunction

	function automatic logic [31:0] q30(real v);
		return 32'(longint'(v * 1073741824.0));
	endfunction

	// Offer one item and hold it until it is taken
	task automatic send_atom(atom_t a);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= S_DATA_W'({a.id, a.weight, a.z, a.y, a.x});
		s_tuser <= a.first;
		s_tlast <= a.last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_atom(a);
		atoms_sent++;
	endtask

	task automatic send_bead(int n, bead_kind_t kind);
		atom_t a;
		longint cx, cy, cz;
		int unsigned reach;
		logic [ID_W-1:0] id;
		id = $urandom_range(0, 65535);
		if (kind == BEAD_EDGE) begin
			cx = rim_point();
			cy = rim_point();
			cz = rim_point();
			reach = atom_reach * 2;
		end else begin
			cx = $signed(near_coord(0, center_reach));
			cy = $signed(near_coord(0, center_reach));
			cz = $signed(near_coord(0, center_reach));
			reach = atom_reach;
		end
		for (int i = 0; i < n; i++) begin
			a.x = (i == 0) ? COORD_W'(cx) : near_coord(cx, reach);
			a.y = (i == 0) ? COORD_W'(cy) : near_coord(cy, reach);
			a.z = (i == 0) ? COORD_W'(cz) : near_coord(cz, reach);
			a.weight = pick_weight();
			a.first = (i == 0) && (kind != BEAD_NO_FIRST);
			a.last = (i == n - 1) && (kind != BEAD_NO_LAST);
			a.id = (kind == BEAD_MIXED_ID) ? ID_W'($urandom) : id;
			send_atom(a);
		end
	endtask

	// Mostly well-formed beads; some broken ones, stray atoms and rim beads
	task automatic run_random(int n_atoms);
		int stop_at;
		int pick;
		stop_at = atoms_sent + n_atoms;
		while (atoms_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_bead($urandom_range(1, (pick < 7) ? 12 : 6), BEAD_CLEAN);
			else if (pick < 74)
				send_bead($urandom_range(1, 6), BEAD_NO_FIRST);
			else if (pick < 78)
				send_bead($urandom_range(1, 6), BEAD_NO_LAST);
			else if (pick < 82)
				send_bead($urandom_range(1, 6), BEAD_MIXED_ID);
			else if (pick < 91)
				send_atom(mk_atom($urandom, $urandom, $urandom, WEIGHT_W'($urandom),
					$urandom_range(0, 1), $urandom_range(0, 1), ID_W'($urandom)));
			else
				send_bead($urandom_range(1, 4), BEAD_EDGE);
		end
	endtask

	// Write one register; the caller lowers the enable after a batch
	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	// Load a triclinic box and its inverse; scale the stimulus to it
	task automatic load_box(real lx, real ly, real lz, real xy, real xz, real yz);
		real big;
		longint span;
		write_reg(REG_BOX_LX_LY, {q16(ly), q16(lx)});
		write_reg(REG_BOX_LZ_XY, {q16(xy), q16(lz)});
		write_reg(REG_BOX_XZ_YZ, {q16(yz), q16(xz)});
		write_reg(REG_INV_00_11, {q30(1.0 / ly), q30(1.0 / lx)});
		write_reg(REG_INV_22_01, {q30(-xy / (lx * ly)), q30(1.0 / lz)});
		write_reg(REG_INV_02_12, {q30(-yz / (ly * lz)),
			q30((xy * yz - xz * ly) / (lx * ly * lz))});
		cfg_we <= 1'b0;
		big = (lx > ly) ? lx : ly;
		big = (lz > big) ? lz : big;
		span = longint'(big * 65536.0);
		atom_reach = int'(span * 3 / 2);
		center_reach = (span * 4 > (64'sd1 <<< 30)) ? (32'd1 << 30) : int'(span * 4);
	endtask

	task automatic load_random_box();
		real lx, ly, lz;
		lx = 5.0 + $urandom_range(0, 4000) / 100.0;
		ly = 5.0 + $urandom_range(0, 4000) / 100.0;
		lz = 5.0 + $urandom_range(0, 4000) / 100.0;
		load_box(lx, ly, lz,
			($urandom_range(0, 1000) / 1000.0 - 0.5) * lx,
			($urandom_range(0, 1000) / 1000.0 - 0.5) * lx,
			($urandom_range(0, 1000) / 1000.0 - 0.5) * ly);
	endtask

	// Drop valid, wait for every due bead, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		board = new();
		arst_n <= 1'b0;
		s_tdata <= '0;
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		s_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed atoms with the all-zero box left by reset
		// later atom with no reference yet
		send_atom(mk_atom(32'h1234_5678, -5, 32'h7FFF_FFFF, WEIGHT_ONE, 0, 1, 16'hFFFF));
		// one-atom bead at the coordinate extremes
		send_atom(mk_atom(32'h7FFF_FFFF, 32'h8000_0000, 0, WEIGHT_ONE, 1, 1, 16'h0000));
		// weight above one
		send_atom(mk_atom(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 17'h1FFFF, 1, 1,
			16'h00A5));
		// emission rounding at exactly one half
		send_atom(mk_atom(1, -1, 3, 17'd32768, 1, 1, 16'h5A00));
		// sums beyond the output range, both signs
		send_atom(mk_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, WEIGHT_ONE, 1, 0, 7));
		send_atom(mk_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, WEIGHT_ONE, 0, 0, 7));
		send_atom(mk_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, WEIGHT_ONE, 0, 1, 7));
		send_atom(mk_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, WEIGHT_ONE, 1, 0, 8));
		send_atom(mk_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, WEIGHT_ONE, 0, 0, 8));
		send_atom(mk_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, WEIGHT_ONE, 0, 1, 8));
		// zero weights
		send_atom(mk_atom(0, 0, 0, 0, 1, 0, 9));
		send_atom(mk_atom(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000, 0, 0, 1, 9));
		// bead left open, then restarted by a new reference atom
		send_atom(mk_atom(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, WEIGHT_ONE, 1, 0, 10));
		send_atom(mk_atom(32'h0006_0000, 32'h0006_0000, 32'h0006_0000, WEIGHT_ONE, 1, 0, 11));
		send_atom(mk_atom(32'h0007_0000, 32'h0007_0000, 32'h0007_0000, WEIGHT_ONE, 0, 1, 11));
		// after emission, a later atom reuses the kept state
		send_atom(mk_atom(32'h0008_0000, 32'h0008_0000, 32'h0008_0000, WEIGHT_ONE, 0, 1, 12));
		send_atom(mk_atom(32'h0009_0000, 32'hFFF7_0000, 32'h0001_0000, 17'h10001, 1, 0, 13));
		send_atom(mk_atom(32'h000A_0000, 32'hFFF6_0000, 32'h0002_0000, 17'h0FFFF, 0, 0, 13));
		send_atom(mk_atom(32'h000B_0000, 32'hFFF5_0000, 32'h0003_0000, 17'h08000, 0, 1, 14));
		// alternating bit patterns
		send_atom(mk_atom(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 17'h0AAAA, 1, 0,
			16'hAAAA));
		send_atom(mk_atom(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 17'h15555, 0, 1,
			16'h5555));
		settle();

		// Orthorhombic box
		load_box(5.0 + $urandom_range(0, 4500) / 100.0, 5.0 + $urandom_range(0, 4500) / 100.0,
			5.0 + $urandom_range(0, 4500) / 100.0, 0.0, 0.0, 0.0);
		run_random(250);
		settle();

		// Triclinic box; hold the receiver off so the unit backs up
		load_random_box();
		run_random(100);
		hold_left = HOLD_CYCLES;
		run_random(150);
		settle();

		// Extreme register values; the write past the list must be ignored
		write_reg(REG_BOX_LX_LY, 64'h7FFF_FFFF_8000_0000);
		write_reg(REG_BOX_LZ_XY, 64'h7FFF_FFFF_8000_0000);
		write_reg(REG_BOX_XZ_YZ, 64'h8000_0000_7FFF_FFFF);
		write_reg(REG_INV_00_11, 64'h7FFF_FFFF_7FFF_FFFF);
		write_reg(REG_INV_22_01, 64'h8000_0000_8000_0000);
		write_reg(REG_INV_02_12, 64'h7FFF_FFFF_8000_0000);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_we <= 1'b0;
		center_reach = 32'd1 << 30;
		atom_reach = 32'd1 << 30;
		run_random(120);
		settle();

		// All ones on the box, raw random inverse
		write_reg(REG_BOX_LX_LY, '1);
		write_reg(REG_BOX_LZ_XY, '1);
		write_reg(REG_BOX_XZ_YZ, '1);
		write_reg(REG_INV_00_11, {$urandom, $urandom});
		write_reg(REG_INV_22_01, {$urandom, $urandom});
		write_reg(REG_INV_02_12, {$urandom, $urandom});
		cfg_we <= 1'b0;
		run_random(120);
		settle();

		// Back-to-back traffic: a bead long enough to saturate the sums
		load_random_box();
		no_idle = 1'b1;
		for (int i = 0; i < 260; i++)
			send_atom(mk_atom(32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_FFFF, WEIGHT_ONE,
				i == 0, i == 259, 16'h0F0F));
		run_random(60);
		no_idle = 1'b0;
		run_random(60);
		settle();

		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
